FILE: rtl/srrip_pkg.sv
package srrip_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int DEFAULT_TAG_BITS = 32;
    localparam int PAGE_BITS        = 32;
    localparam int WAYS_BITS        = 5;

    localparam logic [WAYS_BITS-1:0] WAYS_RESET = 5'd16;

    localparam int RRPV_W = 2;
    localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd0;
    localparam logic [RRPV_W-1:0] RRPV_INSERT  = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;

    typedef struct packed {
        logic [PAGE_BITS-1:0] evicted_page;
        logic                 evicted_valid;
        logic                 hit;
    } res_t;

endpackage

FILE: rtl/srrip_entry_store.sv
module srrip_entry_store
    import srrip_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_CAPACITY,
    parameter int WIDTH  = DEFAULT_TAG_BITS + RRPV_W + 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/srrip_seq.sv
module srrip_seq
    import srrip_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int TAG_BITS = DEFAULT_TAG_BITS,
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int ENT_W   = TAG_BITS + RRPV_W + IDX_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [WAYS_BITS-1:0] ways,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PAGE_BITS-1:0] in_page,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_t                 res,
    output logic                 ram_rd_en,
    output logic [IDX_W-1:0]     ram_rd_addr,
    input  logic [ENT_W-1:0]     ram_rd_data,
    output logic                 ram_wr_en,
    output logic [IDX_W-1:0]     ram_wr_addr,
    output logic [ENT_W-1:0]     ram_wr_data
);

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > WAYS_BITS) ? CNT_W : WAYS_BITS;
    localparam int RRPV_LSB = IDX_W;
    localparam int TAG_LSB  = IDX_W + RRPV_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    filled_reg, filled_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic                hit_reg, hit_next;
    logic                have_reg, have_next;

    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [IDX_W-1:0]    hit_slot_reg, hit_slot_next;
    logic [IDX_W-1:0]    hit_rank_reg, hit_rank_next;
    logic [RRPV_W-1:0]   max_reg, max_next;
    logic [IDX_W-1:0]    vic_slot_reg, vic_slot_next;
    logic [IDX_W-1:0]    vic_rank_reg, vic_rank_next;
    logic [TAG_BITS-1:0] vic_tag_reg, vic_tag_next;
    res_t                res_reg, res_next;

    logic [TAG_BITS+PAGE_BITS-1:0] page_ext;
    logic [TAG_BITS+PAGE_BITS-1:0] vic_ext;
    logic [TAG_BITS-1:0]  ent_tag;
    logic [RRPV_W-1:0]    ent_rrpv;
    logic [IDX_W-1:0]     ent_rank;
    logic [WAYS_BITS-1:0] ways_eff;
    logic                 not_full;
    logic                 issue;
    logic                 pass_end;
    logic [ENT_W-1:0]     append_rec;
    logic [ENT_W-1:0]     upd_rec;
    logic [IDX_W-1:0]     upd_rank;
    logic [RRPV_W-1:0]    upd_rrpv;
    logic [TAG_BITS-1:0]  upd_tag;

    assign page_ext = {{TAG_BITS{1'b0}}, in_page};
    assign vic_ext  = {{PAGE_BITS{1'b0}}, vic_tag_reg};

    assign ent_tag  = ram_rd_data[TAG_LSB +: TAG_BITS];
    assign ent_rrpv = ram_rd_data[RRPV_LSB +: RRPV_W];
    assign ent_rank = ram_rd_data[IDX_W-1:0];

    // zero ways acts as one; above capacity is capped by the second term
    assign ways_eff = (ways == '0) ? WAYS_BITS'(1) : ways;
    assign not_full = (CMP_W'(filled_reg) < CMP_W'(ways_eff))
                   && (filled_reg < CNT_W'(CAPACITY));

    assign issue    = (rd_ptr_reg < filled_reg);
    assign pass_end = !issue && !pend_reg;

    assign append_rec = {tag_reg, RRPV_INSERT, filled_reg[IDX_W-1:0]};

    // write-back record for the second pass: promote on hit, age on replace
    always_comb
    begin
        upd_tag  = ent_tag;
        upd_rrpv = ent_rrpv;
        upd_rank = ent_rank;
        if (hit_reg)
        begin
            if (pend_idx_reg == hit_slot_reg)
            begin
                upd_rrpv = RRPV_NEAR;
                upd_rank = '0;
            end
            else if (ent_rank < hit_rank_reg)
            begin
                upd_rank = ent_rank + IDX_W'(1);
            end
        end
        else
        begin
            upd_rrpv = ent_rrpv + (RRPV_DISTANT - max_reg);
            if (pend_idx_reg == vic_slot_reg)
            begin
                upd_tag  = tag_reg;
                upd_rrpv = RRPV_INSERT;
            end
        end
        upd_rec = {upd_tag, upd_rrpv, upd_rank};
    end

    always_comb
    begin
        state_next    = state_reg;
        filled_next   = filled_reg;
        rd_ptr_next   = rd_ptr_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        have_next     = have_reg;
        tag_next      = tag_reg;
        hit_slot_next = hit_slot_reg;
        hit_rank_next = hit_rank_reg;
        max_next      = max_reg;
        vic_slot_next = vic_slot_reg;
        vic_rank_next = vic_rank_reg;
        vic_tag_next  = vic_tag_reg;
        res_next      = res_reg;

        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_ptr_reg[IDX_W-1:0];
        ram_wr_en   = 1'b0;
        ram_wr_addr = pend_idx_reg;
        ram_wr_data = upd_rec;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tag_next    = page_ext[TAG_BITS-1:0];
                    rd_ptr_next = '0;
                    pend_next   = 1'b0;
                    hit_next    = 1'b0;
                    have_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    ram_rd_en     = 1'b1;
                    rd_ptr_next   = rd_ptr_reg + CNT_W'(1);
                    pend_idx_next = rd_ptr_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    if (ent_tag == tag_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = pend_idx_reg;
                        hit_rank_next = ent_rank;
                    end
                    // victim: front-most entry among those with the largest rrpv
                    if (!have_reg || (ent_rrpv > max_reg)
                        || ((ent_rrpv == max_reg) && (ent_rank < vic_rank_reg)))
                    begin
                        have_next     = 1'b1;
                        max_next      = ent_rrpv;
                        vic_slot_next = pend_idx_reg;
                        vic_rank_next = ent_rank;
                        vic_tag_next  = ent_tag;
                    end
                end
                if (pass_end)
                begin
                    rd_ptr_next = '0;
                    if (hit_reg)
                    begin
                        res_next.hit           = 1'b1;
                        res_next.evicted_valid = 1'b0;
                        res_next.evicted_page  = '0;
                        state_next             = ST_UPDATE;
                    end
                    else if (not_full)
                    begin
                        ram_wr_en              = 1'b1;
                        ram_wr_addr            = filled_reg[IDX_W-1:0];
                        ram_wr_data            = append_rec;
                        filled_next            = filled_reg + CNT_W'(1);
                        res_next.hit           = 1'b0;
                        res_next.evicted_valid = 1'b0;
                        res_next.evicted_page  = '0;
                        state_next             = ST_DONE;
                    end
                    else
                    begin
                        res_next.hit           = 1'b0;
                        res_next.evicted_valid = 1'b1;
                        res_next.evicted_page  = vic_ext[PAGE_BITS-1:0];
                        state_next             = ST_UPDATE;
                    end
                end
            end

            ST_UPDATE:
            begin
                // read of entry i+1 overlaps write-back of entry i
                pend_next = issue;
                if (issue)
                begin
                    ram_rd_en     = 1'b1;
                    rd_ptr_next   = rd_ptr_reg + CNT_W'(1);
                    pend_idx_next = rd_ptr_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    ram_wr_en = 1'b1;
                end
                if (pass_end)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            filled_reg <= '0;
            rd_ptr_reg <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            have_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            filled_reg <= filled_next;
            rd_ptr_reg <= rd_ptr_next;
            pend_reg   <= pend_next;
            hit_reg    <= hit_next;
            have_reg   <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        tag_reg      <= tag_next;
        hit_slot_reg <= hit_slot_next;
        hit_rank_reg <= hit_rank_next;
        max_reg      <= max_next;
        vic_slot_reg <= vic_slot_next;
        vic_rank_reg <= vic_rank_next;
        vic_tag_reg  <= vic_tag_next;
        res_reg      <= res_next;
    end

endmodule

FILE: rtl/srrip_page_replacement_unit.sv
// Channel   Dir  Beat / write                     Payload
// s_axis    in   s_axis_tvalid & s_axis_tready    tdata[31:0] page
// m_axis    out  m_axis_tvalid & m_axis_tready    tdata[31:0] evicted_page,
//                                                 tuser[0] hit, tuser[1] evicted_valid
// cfg       in   cfg_we                           cfg_wdata[4:0] ways_in_use
//
// A hit or eviction shows its beat after a scan pass and an update pass over the entries,
// an append after the scan pass alone; the input is ready again as the beat shows.
// Each pass reads the entry memory through its single read port, one entry a cycle.
// Reset clears the fill count; the entry memory is not cleared and needs no sweep.
// The result sits in an output register, so the next page is taken while it waits;
// a stalled output holds the sequencer only once its next result is ready.
module srrip_page_replacement_unit
    import srrip_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int TAG_BITS = DEFAULT_TAG_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // [31:0] page
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [31:0] evicted_page
    output logic [1:0]           m_axis_tuser,   // [0] hit, [1] evicted_valid
    input  logic                 cfg_we,
    input  logic [WAYS_BITS-1:0] cfg_wdata       // ways_in_use
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ENT_W = TAG_BITS + RRPV_W + IDX_W;

    logic [WAYS_BITS-1:0] ways_reg, ways_next;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_reg, out_next;

    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [ENT_W-1:0] ram_rd_data;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic [ENT_W-1:0] ram_wr_data;

    srrip_seq #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .ways        (ways_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_page     (s_axis_tdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    srrip_entry_store #(
        .DEPTH (CAPACITY),
        .WIDTH (ENT_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        ways_next      = cfg_we ? cfg_wdata : ways_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg      <= WAYS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ways_reg      <= ways_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg.evicted_page;
    assign m_axis_tuser  = {out_reg.evicted_valid, out_reg.hit};

endmodule

FILE: rtl/srrip_checker.sv
module srrip_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [31:0]          m_axis_tdata,
    input logic [1:0]           m_axis_tuser
);

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("hit beat also reports an eviction");

    // no eviction means a zero page field
    a_evict_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata == 32'd0))
        else $error("evicted page nonzero without eviction");

    // one page in flight: the input closes right after a beat
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

endmodule

bind srrip_page_replacement_unit srrip_checker u_chk (.*);
